/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DFS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("dfs assertion failed");

// next-cycle implication
`define DFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("dfs assertion failed");

`endif

/* hw/rtl/dfs_pkg.sv */
// ----------------------------------------------------------------------------
// dfs_pkg
// Types and constants of the depth-first search engine
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

	// default sizes
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_EDGES    = 256;

	// fixed field widths
	localparam int VTX_W = 6;
	localparam int CFG_W = 6;

	// configuration register indexes
	localparam logic [0:0] CFG_UNDIRECTED = 1'b0;
	localparam logic [0:0] CFG_VCOUNT     = 1'b1;

	// operation codes
	localparam logic OP_EDGE   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// result status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_RANGE = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	typedef struct packed {
		logic             op;
		logic [VTX_W-1:0] vertex_a;
		logic [VTX_W-1:0] vertex_b;
	} req_t;

	typedef struct packed {
		logic [VTX_W-1:0] visited_vertex;
		logic             last;
		logic [1:0]       status;
	} rsp_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_ACK,
		S_LINK_A,
		S_LINK_RD_B,
		S_LINK_B,
		S_ROOT,
		S_SCAN,
		S_POP,
		S_TEST,
		S_DESC,
		S_FINAL
	} dfs_state_t;

	// graph store strobes
	typedef struct packed {
		logic head_rd;
		logic head_wr;
		logic edge_rd;
		logic edge_wr;
	} gs_ctrl_t;

	// walk stack strobes
	typedef struct packed {
		logic rd;
		logic wr;
	} ws_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/dfs_graph_store.sv */
// ----------------------------------------------------------------------------
// dfs_graph_store
// List heads per vertex and the edge entry store, registered reads
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_graph_store import dfs_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire gs_ctrl_t                            ctrl,
	input  wire logic [$clog2(MAX_VERTICES)-1:0]     head_addr,
	input  wire logic [$clog2(MAX_EDGES):0]          head_wr_data,
	output      logic [$clog2(MAX_EDGES):0]          head_rd_data,
	input  wire logic [$clog2(MAX_EDGES)-1:0]        edge_addr,
	input  wire logic [VTX_W-1:0]                    edge_wr_target,
	input  wire logic [$clog2(MAX_EDGES):0]          edge_wr_next,
	output      logic [VTX_W-1:0]                    edge_rd_target,
	output      logic [$clog2(MAX_EDGES):0]          edge_rd_next
);

	localparam int EA = $clog2(MAX_EDGES);
	localparam int EW = EA + 1;
	localparam logic [EW-1:0] END_MARK = EW'(MAX_EDGES);

	logic [EW-1:0]         head_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] head_vld_q;
	logic [EW-1:0]         head_rd_q;
	logic                  head_hit_q;
	logic [VTX_W+EW-1:0]   edge_mem [MAX_EDGES];
	logic [VTX_W+EW-1:0]   edge_rd_q;

	// list head memory
	always_ff @(posedge clk) begin
		if (ctrl.head_wr) begin
			head_mem[head_addr] <= head_wr_data;
		end
		if (ctrl.head_rd) begin
			head_rd_q <= head_mem[head_addr];
		end
	end

	// written marks, an unwritten head reads as the end marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
			head_hit_q <= 1'b0;
		end else begin
			if (ctrl.head_wr) begin
				head_vld_q[head_addr] <= 1'b1;
			end
			if (ctrl.head_rd) begin
				head_hit_q <= head_vld_q[head_addr];
			end
		end
	end

	assign head_rd_data = head_hit_q ? head_rd_q : END_MARK;

	// edge entries: target vertex and link to the next entry
	always_ff @(posedge clk) begin
		if (ctrl.edge_wr) begin
			edge_mem[edge_addr] <= {edge_wr_target, edge_wr_next};
		end
		if (ctrl.edge_rd) begin
			edge_rd_q <= edge_mem[edge_addr];
		end
	end

	assign edge_rd_target = edge_rd_q[VTX_W+EW-1:EW];
	assign edge_rd_next   = edge_rd_q[EW-1:0];

endmodule

`default_nettype wire

/* hw/rtl/dfs_walk_stack.sv */
// ----------------------------------------------------------------------------
// dfs_walk_stack
// Saved list cursors of the vertices below the top of the walk
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_walk_stack import dfs_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
	input  wire logic                             clk,
	input  wire ws_ctrl_t                         ctrl,
	input  wire logic [$clog2(MAX_VERTICES)-1:0]  addr,
	input  wire logic [$clog2(MAX_EDGES):0]       wr_data,
	output      logic [$clog2(MAX_EDGES):0]       rd_data
);

	localparam int EW = $clog2(MAX_EDGES) + 1;

	logic [EW-1:0] stack_mem [MAX_VERTICES];
	logic [EW-1:0] rd_q;

	// single port cursor memory
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			stack_mem[addr] <= wr_data;
		end
		if (ctrl.rd) begin
			rd_q <= stack_mem[addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

/* hw/rtl/depth_first_search_engine_unit.sv */
// ----------------------------------------------------------------------------
// depth_first_search_engine_unit
// Adjacency list store and depth-first walk engine with explicit stack
// ----------------------------------------------------------------------------
//  channel  | signals                         | request
//  ---------+---------------------------------+-----------------------------
//  req      | req_valid, req_ready, req_data  | edge load or search start
//  rsp      | rsp_valid, rsp_ready, rsp_data  | visited vertex or status
//  cfg      | cfg_we, cfg_index, cfg_data     | register write, no wait
//
//  An error skips the link states; a directed edge is linked from vertex_a,
//  an undirected edge also from vertex_b. A search scans stored edges,
//  descends and backtracks through the single-port edge and stack memories.
//  req_ready is high only while the sequencer is idle.
//  A stalled rsp channel holds the walk at its next result; reset needs no
//  clearing pass, list heads carry written marks.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_first_search_engine_unit import dfs_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output      logic              req_ready,
	input  wire req_t              req_data,
	output      logic              rsp_valid,
	input  wire logic              rsp_ready,
	output      rsp_t              rsp_data,
	input  wire logic              cfg_we,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	localparam int VA = $clog2(MAX_VERTICES);
	localparam int EA = $clog2(MAX_EDGES);
	localparam int EW = EA + 1;
	localparam int SW = $clog2(MAX_VERTICES + 1);
	localparam logic [EW-1:0]    END_MARK  = EW'(MAX_EDGES);
	localparam logic [EW:0]      EDGE_CAP  = (EW+1)'(MAX_EDGES);
	localparam logic [VTX_W-1:0] VTX_TOP   = VTX_W'(MAX_VERTICES - 1);
	localparam logic [SW-1:0]    STACK_CAP = SW'(MAX_VERTICES);
	localparam logic [SW-1:0]    SP_ONE    = SW'(1);

	dfs_state_t state_q, state_d;

	// configuration registers
	logic             undirected_q;
	logic [VTX_W-1:0] vcount_q;

	// item and walk registers
	logic [VTX_W-1:0] a_q, b_q, pend_q;
	logic [1:0]       status_q;
	logic [EW-1:0]    fill_q;
	logic [EW-1:0]    cur_q;
	logic [SW-1:0]    sp_q;
	logic [MAX_VERTICES-1:0] visited_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	// memory interfaces
	gs_ctrl_t         gs_ctrl;
	ws_ctrl_t         ws_ctrl;
	logic [VA-1:0]    head_addr;
	logic [EW-1:0]    head_rd_data;
	logic [EA-1:0]    edge_addr;
	logic [VTX_W-1:0] edge_wr_target;
	logic [VTX_W-1:0] edge_rd_target;
	logic [EW-1:0]    edge_rd_next;
	logic [VA-1:0]    stack_addr;
	logic [EW-1:0]    stack_rd_data;

	// decisions
	logic [VTX_W-1:0] lim;
	logic             a_ok, b_ok, full;
	logic [1:0]       chk_status;
	logic             out_free, cur_end, take, take_go, rsp_load;
	logic [SW-1:0]    sp_m1, sp_m2;
	rsp_t             rsp_next;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			undirected_q <= 1'b1;
			vcount_q     <= VTX_W'(63);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UNDIRECTED: undirected_q <= cfg_data[0];
				CFG_VCOUNT:     vcount_q     <= cfg_data[VTX_W-1:0];
				default:        ;
			endcase
		end
	end

	// range and fill checks on the incoming request
	assign lim  = (vcount_q > VTX_TOP) ? VTX_TOP : vcount_q;
	assign a_ok = (req_data.vertex_a != '0) && (req_data.vertex_a <= lim);
	assign b_ok = (req_data.vertex_b != '0) && (req_data.vertex_b <= lim);
	assign full = ({1'b0, fill_q} + (undirected_q ? (EW+1)'(2) : (EW+1)'(1))) > EDGE_CAP;

	always_comb begin
		if (!a_ok || (req_data.op == OP_EDGE && !b_ok)) begin
			chk_status = STS_RANGE;
		end else if (req_data.op == OP_EDGE && full) begin
			chk_status = STS_FULL;
		end else begin
			chk_status = STS_OK;
		end
	end

	// walk decisions
	assign out_free = !rsp_valid_q || rsp_ready;
	assign cur_end  = cur_q >= END_MARK;
	assign take     = (edge_rd_target != '0) && (edge_rd_target <= lim) &&
		!visited_q[edge_rd_target[VA-1:0]] && (sp_q < STACK_CAP);
	assign sp_m1    = sp_q - SW'(1);
	assign sp_m2    = sp_q - SW'(2);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (chk_status != STS_OK) begin
						state_d = S_ACK;
					end else if (req_data.op == OP_SEARCH) begin
						state_d = S_ROOT;
					end else begin
						state_d = S_LINK_A;
					end
				end
			end
			S_LINK_A:    state_d = undirected_q ? S_LINK_RD_B : S_ACK;
			S_LINK_RD_B: state_d = S_LINK_B;
			S_LINK_B:    state_d = S_ACK;
			S_ACK: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_ROOT: state_d = S_SCAN;
			S_SCAN: begin
				if (!cur_end) begin
					state_d = S_TEST;
				end else if (sp_q == SP_ONE) begin
					state_d = S_FINAL;
				end else begin
					state_d = S_POP;
				end
			end
			S_POP: state_d = S_SCAN;
			S_TEST: begin
				if (!take) begin
					state_d = S_SCAN;
				end else if (out_free) begin
					state_d = S_DESC;
				end
			end
			S_DESC: state_d = S_SCAN;
			S_FINAL: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready      = 1'b0;
		gs_ctrl        = '0;
		ws_ctrl        = '0;
		take_go        = 1'b0;
		rsp_load       = 1'b0;
		head_addr      = a_q[VA-1:0];
		edge_addr      = fill_q[EA-1:0];
		edge_wr_target = b_q;
		stack_addr     = sp_m1[VA-1:0];
		rsp_next       = '{visited_vertex: pend_q, last: 1'b0, status: STS_OK};
		case (state_q)
			S_IDLE: begin
				req_ready       = 1'b1;
				gs_ctrl.head_rd = req_valid;
				head_addr       = req_data.vertex_a[VA-1:0];
			end
			S_LINK_A: begin
				gs_ctrl.head_wr = 1'b1;
				gs_ctrl.edge_wr = 1'b1;
			end
			S_LINK_RD_B: begin
				gs_ctrl.head_rd = 1'b1;
				head_addr       = b_q[VA-1:0];
			end
			S_LINK_B: begin
				gs_ctrl.head_wr = 1'b1;
				gs_ctrl.edge_wr = 1'b1;
				head_addr       = b_q[VA-1:0];
				edge_wr_target  = a_q;
			end
			S_ACK: begin
				rsp_load = out_free;
				rsp_next = '{visited_vertex: '0, last: 1'b1, status: status_q};
			end
			S_SCAN: begin
				gs_ctrl.edge_rd = !cur_end;
				edge_addr       = cur_q[EA-1:0];
				ws_ctrl.rd      = cur_end && (sp_q != SP_ONE);
				stack_addr      = sp_m2[VA-1:0];
			end
			S_TEST: begin
				take_go         = take && out_free;
				rsp_load        = take_go;
				gs_ctrl.head_rd = take_go;
				head_addr       = edge_rd_target[VA-1:0];
				ws_ctrl.wr      = take_go;
			end
			S_FINAL: begin
				rsp_load = out_free;
				rsp_next = '{visited_vertex: pend_q, last: 1'b1, status: STS_OK};
			end
			default: ;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			visited_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (gs_ctrl.edge_wr) begin
				fill_q <= fill_q + EW'(1);
			end
			if (state_q == S_ROOT) begin
				visited_q[a_q[VA-1:0]] <= 1'b1;
			end else if (take_go) begin
				visited_q[edge_rd_target[VA-1:0]] <= 1'b1;
			end else if (state_q == S_FINAL && out_free) begin
				visited_q <= '0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// item and walk payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			a_q      <= req_data.vertex_a;
			b_q      <= req_data.vertex_b;
			status_q <= chk_status;
		end
		case (state_q)
			S_ROOT: begin
				pend_q <= a_q;
				cur_q  <= head_rd_data;
				sp_q   <= SP_ONE;
			end
			S_POP: begin
				cur_q <= stack_rd_data;
				sp_q  <= sp_m1;
			end
			S_TEST: begin
				if (!take) begin
					cur_q <= edge_rd_next;
				end else if (out_free) begin
					pend_q <= edge_rd_target;
				end
			end
			S_DESC: begin
				cur_q <= head_rd_data;
				sp_q  <= sp_q + SW'(1);
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	dfs_graph_store #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_store (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (gs_ctrl),
		.head_addr      (head_addr),
		.head_wr_data   (fill_q),
		.head_rd_data   (head_rd_data),
		.edge_addr      (edge_addr),
		.edge_wr_target (edge_wr_target),
		.edge_wr_next   (head_rd_data),
		.edge_rd_target (edge_rd_target),
		.edge_rd_next   (edge_rd_next)
	);

	dfs_walk_stack #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_stack (
		.clk     (clk),
		.ctrl    (ws_ctrl),
		.addr    (stack_addr),
		.wr_data (edge_rd_next),
		.rd_data (stack_rd_data)
	);

endmodule

`default_nettype wire

/* hw/rtl/dfs_checker.sv */
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks on the depth-first search engine
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dfs_checker import dfs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req_data,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp_data
);

	logic req_wait;
	logic rsp_wait;
	logic rsp_err;
	logic err_shape;
	logic status_known;

	// handshake and result views
	assign req_wait     = req_valid && !req_ready;
	assign rsp_wait     = rsp_valid && !rsp_ready;
	assign rsp_err      = rsp_valid && rsp_data.status != STS_OK;
	assign err_shape    = rsp_data.last && rsp_data.visited_vertex == '0;
	assign status_known = rsp_data.status == STS_OK || rsp_data.status == STS_RANGE ||
		rsp_data.status == STS_FULL;

	// a waiting request holds
	`DFS_ASSERT_NEXT(a_req_hold, clk, arst_n, req_wait, req_valid && $stable(req_data))

	// a waiting result holds
	`DFS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_wait, rsp_valid && $stable(rsp_data))

	// the engine is busy right after taking a request
	`DFS_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)

	// only the closing result of an item may carry an error
	`DFS_ASSERT_NOW(a_err_is_last, clk, arst_n, rsp_err, err_shape)

	// status stays within its codes
	`DFS_ASSERT_NOW(a_status_code, clk, arst_n, rsp_valid, status_known)

endmodule

bind depth_first_search_engine_unit dfs_checker u_dfs_checker (.*);

`default_nettype wire
